### rtl/core/pwrbtn_pkg.sv
// ----------------------------------------------------------------------------
// Power button mode controller package
// Mode codes, duty levels, register indexes and reset values shared by the
// controller.
// ----------------------------------------------------------------------------
package pwrbtn_pkg;

    localparam int DUTY_W  = 5;
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = 5;

    typedef enum logic [1:0] {
        MODE_ON      = 2'd0,
        MODE_SHUT    = 2'd1,
        MODE_STANDBY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_ON_HOLD  = 3'd0,
        REG_OFF_HOLD = 3'd1,
        REG_BRIGHT   = 3'd2,
        REG_DIM      = 3'd3,
        REG_START    = 3'd4
    } reg_index_t;

    localparam logic [DUTY_W-1:0] DUTY_BRIGHT    = 5'd19;
    localparam logic [DUTY_W-1:0] DUTY_DIM       = 5'd5;
    localparam logic [DUTY_W-1:0] DUTY_SHUT      = 5'd5;
    localparam logic [DUTY_W-1:0] DUTY_OFF       = 5'd4;
    localparam logic [DUTY_W-1:0] DUTY_THRESHOLD = 5'd12;

    localparam logic [COUNT_W-1:0] ON_HOLD_RESET  = 8'd80;
    localparam logic [COUNT_W-1:0] OFF_HOLD_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] BRIGHT_RESET   = 8'd2;
    localparam logic [COUNT_W-1:0] DIM_RESET      = 8'd10;
    localparam logic [COUNT_W-1:0] START_RESET    = 8'd25;

endpackage

### rtl/core/power_button_mode_controller.sv
// ----------------------------------------------------------------------------
// Power button mode controller
// Steps the on / shutting down / off mode and the flashing PWM duty for each
// tick or button level change, and returns the duty and mode per item.
// ----------------------------------------------------------------------------
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless m_tready stalls it, set by the input
// register feeding the result register through one pass of update logic.
// Reset: asynchronous and active low; the mode returns to on with duty 19,
// the flash count to 25, the hold count to 0 and the registers to defaults.
// ----------------------------------------------------------------------------
module power_button_mode_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] comp_level, [7:1] zero
    input  logic [0:0]  s_tuser,   // [0] action
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [4:0] duty, [6:5] mode, [7] zero
);

    import pwrbtn_pkg::*;

    logic [COUNT_W-1:0] on_hold_reg;
    logic [COUNT_W-1:0] off_hold_reg;
    logic [COUNT_W-1:0] bright_reg;
    logic [COUNT_W-1:0] dim_reg;
    logic [COUNT_W-1:0] start_reg;

    logic               in_valid_reg;
    logic               in_action_reg;
    logic               in_level_reg;

    logic               out_valid_reg;
    logic [DUTY_W-1:0]  out_duty_reg;
    mode_t              out_mode_reg;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [DUTY_W-1:0]  duty_reg;
    logic [DUTY_W-1:0]  duty_next;
    logic [COUNT_W-1:0] flash_reg;
    logic [COUNT_W-1:0] flash_next;
    logic [COUNT_W-1:0] hold_reg;
    logic [COUNT_W-1:0] hold_next;

    logic               cfg_write;
    reg_index_t         cfg_index;
    logic               advance;
    logic               step;
    logic [COUNT_W-1:0] flash_dec;
    logic [COUNT_W-1:0] hold_dec;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_comb
    begin
        case (cfg_index)
            REG_ON_HOLD:  prdata = {24'd0, on_hold_reg};
            REG_OFF_HOLD: prdata = {24'd0, off_hold_reg};
            REG_BRIGHT:   prdata = {24'd0, bright_reg};
            REG_DIM:      prdata = {24'd0, dim_reg};
            REG_START:    prdata = {24'd0, start_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_hold_reg  <= ON_HOLD_RESET;
            off_hold_reg <= OFF_HOLD_RESET;
            bright_reg   <= BRIGHT_RESET;
            dim_reg      <= DIM_RESET;
            start_reg    <= START_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ON_HOLD:  on_hold_reg  <= pwdata[7:0];
                REG_OFF_HOLD: off_hold_reg <= pwdata[7:0];
                REG_BRIGHT:   bright_reg   <= pwdata[7:0];
                REG_DIM:      dim_reg      <= pwdata[7:0];
                REG_START:    start_reg    <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or
    // is being emptied in the same cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser[0];
            in_level_reg  <= s_tdata[0];
        end
    end

    assign flash_dec = flash_reg - 8'd1;
    assign hold_dec  = hold_reg - 8'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        duty_next  = duty_reg;
        flash_next = flash_reg;
        hold_next  = hold_reg;
        if (!in_action_reg)
        begin
            if (mode_reg == MODE_ON)
            begin
                flash_next = flash_dec;
                if (flash_dec == 8'd0)
                begin
                    if (duty_reg <= DUTY_THRESHOLD)
                    begin
                        duty_next  = DUTY_BRIGHT;
                        flash_next = bright_reg;
                    end
                    else
                    begin
                        duty_next  = DUTY_DIM;
                        flash_next = dim_reg;
                    end
                end
            end
            if (hold_reg != 8'd0)
            begin
                hold_next = hold_dec;
                if (hold_dec == 8'd0)
                begin
                    case (mode_reg)
                        MODE_ON:
                        begin
                            duty_next = DUTY_SHUT;
                            mode_next = MODE_SHUT;
                        end
                        MODE_SHUT:
                        begin
                            duty_next = DUTY_OFF;
                            mode_next = MODE_STANDBY;
                        end
                        default:
                        begin
                            duty_next  = DUTY_BRIGHT;
                            mode_next  = MODE_ON;
                            flash_next = start_reg;
                        end
                    endcase
                end
            end
        end
        else if (mode_reg == MODE_ON)
        begin
            hold_next = in_level_reg ? 8'd0 : on_hold_reg;
        end
        else
        begin
            hold_next = in_level_reg ? off_hold_reg : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ON;
            duty_reg      <= DUTY_BRIGHT;
            flash_reg     <= START_RESET;
            hold_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                mode_reg  <= mode_next;
                duty_reg  <= duty_next;
                flash_reg <= flash_next;
                hold_reg  <= hold_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_duty_reg <= duty_next;
            out_mode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mode_reg, out_duty_reg};

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted item did not reach the result register");

    a_off_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STANDBY) |-> (duty_reg == DUTY_OFF))
        else $error("off mode with a duty other than the off level");

    a_shut_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SHUT) |-> (duty_reg == DUTY_SHUT))
        else $error("shutdown mode with a duty other than the shutdown level");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (!step) |=> ($stable(mode_reg) && $stable(hold_reg) && $stable(flash_reg)))
        else $error("mode state changed without an item being processed");

endmodule
